/* sv/dll_pkg.sv */
// Package for the doubly linked list manager: command and status codes.
// No dependencies.
package dll_pkg;
    localparam logic [3:0] CMD_INS_FRONT = 4'd0;
    localparam logic [3:0] CMD_INS_AT    = 4'd1;
    localparam logic [3:0] CMD_INS_BACK  = 4'd2;
    localparam logic [3:0] CMD_DEL_FRONT = 4'd3;
    localparam logic [3:0] CMD_DEL_AT    = 4'd4;
    localparam logic [3:0] CMD_DEL_BACK  = 4'd5;
    localparam logic [3:0] CMD_CLEAR     = 4'd6;
    localparam logic [3:0] CMD_READ_FWD  = 4'd7;
    localparam logic [3:0] CMD_READ_BACK = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BOUND = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // One result item as it leaves the engine
    typedef struct packed {
        logic [31:0] out_value;
        logic [5:0]  out_index;
        logic [6:0]  length;
        logic [1:0]  status;
        logic        last;
    } t_result;
endpackage

/* sv/dll_node_mem.sv */
// Node store of the list manager: value, forward and backward link per slot.
// Depends on dll_pkg (nothing used beyond style); one write, one read port each.
module dll_node_mem
    import dll_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int AW = 5,
    parameter int PW = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wval,
    input  logic [PW-1:0] i_wnext,
    input  logic [PW-1:0] i_wprev,
    input  logic          i_wen_val,
    input  logic          i_wen_next,
    input  logic          i_wen_prev,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rval,
    output logic [PW-1:0] o_rnext,
    output logic [PW-1:0] o_rprev
);
    logic [31:0]   r_val  [CAPACITY];
    logic [PW-1:0] r_next [CAPACITY];
    logic [PW-1:0] r_prev [CAPACITY];

    // Per-field write enables, registered read
    always_ff @(posedge i_clk) begin
        if (i_we && i_wen_val)  r_val[i_waddr]  <= i_wval;
        if (i_we && i_wen_next) r_next[i_waddr] <= i_wnext;
        if (i_we && i_wen_prev) r_prev[i_waddr] <= i_wprev;
        o_rval  <= r_val[i_raddr];
        o_rnext <= r_next[i_raddr];
        o_rprev <= r_prev[i_raddr];
    end
endmodule

/* sv/doubly_linked_list_manager.sv */
// Top level of the doubly linked list manager: command sequencer and output register.
// Depends on dll_pkg and dll_node_mem.
//
//  channel | dir | payload
//  s_axis  | in  | tdata = cmd[3:0], item_value[35:4], position[41:36], zero to 47
//  m_axis  | out | tdata = out_value, out_index, length, status; tlast = last
//
// Error, clear and unused commands go straight to the output register. Insert at front or
// back passes S_INS and S_INS2; delete at front or back walks to its end node and passes
// S_DEL and S_DEL2. Positional commands walk the links from the head, S_WALK and S_WAIT
// per hop; reads pass S_RD and S_RDO per element. Reset (synchronous, low) empties the
// list; the store needs no clearing. A stalled output holds the sequencer; the next
// command is taken only once every result of the current one has been transferred.
module doubly_linked_list_manager
    import dll_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // cmd, item_value, position
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_value, out_index, length, status
    output logic        m_axis_tlast
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = 7;  // pointer width, null = CAPACITY
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);

    localparam logic [3:0] S_IDLE = 4'd0, S_WALK = 4'd1, S_WAIT = 4'd2,
                           S_INS  = 4'd3, S_INS2 = 4'd4, S_DEL  = 4'd5,
                           S_DEL2 = 4'd6, S_RD   = 4'd7, S_OUT  = 4'd8,
                           S_RDO  = 4'd9;

    logic [3:0]        r_state;
    logic [CAPACITY-1:0] r_used;
    logic [PW-1:0]     r_head, r_tail, r_cur, r_nbr;
    logic [6:0]        r_count, r_step, r_target, r_k;
    logic [3:0]        r_cmd;
    logic [31:0]       r_val;
    logic [AW-1:0]     r_slot;
    logic              r_ovalid;
    t_result           r_out;

    logic          we, wen_val, wen_next, wen_prev;
    logic [AW-1:0] waddr, raddr;
    logic [PW-1:0] wnext, wprev;
    logic [31:0]   rval;
    logic [PW-1:0] rnext, rprev;

    dll_node_mem #(.CAPACITY(CAPACITY), .AW(AW), .PW(PW)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wval(r_val),
        .i_wnext(wnext), .i_wprev(wprev), .i_wen_val(wen_val),
        .i_wen_next(wen_next), .i_wen_prev(wen_prev), .i_raddr(raddr),
        .o_rval(rval), .o_rnext(rnext), .o_rprev(rprev)
    );

    // Lowest free slot (priority encode over the used map)
    logic [AW-1:0] free_slot;
    always_comb begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
            if (!r_used[i]) free_slot = AW'(i);
    end

    wire [3:0]  in_cmd = s_axis_tdata[3:0];
    wire [31:0] in_val = s_axis_tdata[35:4];
    wire [6:0]  in_pos = {1'b0, s_axis_tdata[41:36]};
    wire        in_xfer = s_axis_tvalid && s_axis_tready;
    wire        out_free = !r_ovalid || m_axis_tready;
    wire        is_ins = (r_cmd == CMD_INS_FRONT) || (r_cmd == CMD_INS_AT) ||
                         (r_cmd == CMD_INS_BACK);
    wire        fwd = (r_cmd == CMD_READ_FWD);

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_out.status, r_out.length, r_out.out_index,
                            r_out.out_value};
    assign m_axis_tlast  = r_out.last;

    // Store port control: read the walk pointer, write link updates
    always_comb begin
        raddr = r_cur[AW-1:0];
        we = 1'b0; wen_val = 1'b0; wen_next = 1'b0; wen_prev = 1'b0;
        waddr = r_slot; wnext = r_cur; wprev = r_nbr;
        case (r_state)
            S_INS: begin
                // new node: value, next = r_cur (before), prev = r_nbr
                we = 1'b1; wen_val = 1'b1; wen_next = 1'b1; wen_prev = 1'b1;
            end
            S_INS2: begin
                // neighbors: prev.next = slot, before.prev = slot
                if (r_nbr != NIL) begin
                    we = 1'b1; wen_next = 1'b1; waddr = r_nbr[AW-1:0];
                    wnext = PW'(r_slot);
                end else if (r_cur != NIL) begin
                    we = 1'b1; wen_prev = 1'b1; waddr = r_cur[AW-1:0];
                    wprev = PW'(r_slot);
                end
            end
            S_DEL: begin
                // prev.next = next
                if (rprev != NIL) begin
                    we = 1'b1; wen_next = 1'b1; waddr = rprev[AW-1:0]; wnext = rnext;
                end
            end
            S_DEL2: begin
                // next.prev = prev (held in r_cur/r_nbr)
                if (r_cur != NIL) begin
                    we = 1'b1; wen_prev = 1'b1; waddr = r_cur[AW-1:0]; wprev = r_nbr;
                end
            end
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_used <= '0; r_head <= NIL; r_tail <= NIL;
            r_count <= '0; r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (in_xfer) begin
                    r_cmd <= in_cmd; r_val <= in_val; r_slot <= free_slot;
                    r_out <= '{out_value: 32'd0, out_index: 6'd0, length: r_count,
                               status: ST_OK, last: 1'b1};
                    r_step <= '0; r_target <= in_pos;
                    r_state <= S_OUT;
                    case (in_cmd)
                        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
                            if (in_cmd == CMD_INS_AT && !(in_pos < r_count ||
                                (r_count == 7'd0 && in_pos == 7'd0)))
                                r_out.status <= ST_BOUND;
                            else if (r_count >= 7'(CAPACITY))
                                r_out.status <= ST_FULL;
                            else if (in_cmd == CMD_INS_BACK) begin
                                r_cur <= NIL; r_nbr <= r_tail; r_state <= S_INS;
                            end else if (in_cmd == CMD_INS_FRONT || r_count == 7'd0) begin
                                r_cur <= r_head; r_nbr <= NIL; r_state <= S_INS;
                            end else begin
                                r_cur <= r_head; r_state <= S_WALK;
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
                            if (r_count == 7'd0) r_out.status <= ST_EMPTY;
                            else if (in_cmd == CMD_DEL_AT && in_pos >= r_count)
                                r_out.status <= ST_BOUND;
                            else begin
                                r_cur <= (in_cmd == CMD_DEL_BACK) ? r_tail : r_head;
                                if (in_cmd == CMD_DEL_AT) r_state <= S_WALK;
                                else begin r_target <= '0; r_state <= S_WALK; end
                            end
                        end
                        CMD_CLEAR: begin
                            r_used <= '0; r_head <= NIL; r_tail <= NIL;
                            r_count <= '0; r_out.length <= '0;
                        end
                        CMD_READ_FWD, CMD_READ_BACK: begin
                            if (r_count == 7'd0) r_out.status <= ST_EMPTY;
                            else begin
                                r_cur <= (in_cmd == CMD_READ_FWD) ? r_head : r_tail;
                                r_k <= '0; r_state <= S_RD;
                            end
                        end
                        default: ;
                    endcase
                end
                // Walk: one read per hop until the target node is reached
                S_WALK: r_state <= S_WAIT;
                S_WAIT: begin
                    if (r_step == r_target) begin
                        if (is_ins) begin
                            r_nbr <= rprev; r_state <= S_INS;
                        end else r_state <= S_DEL;
                    end else begin
                        r_cur <= rnext; r_step <= r_step + 7'd1; r_state <= S_WALK;
                    end
                end
                S_INS: r_state <= S_INS2;
                S_INS2: begin
                    if (r_nbr != NIL) begin
                        r_nbr <= NIL; // second neighbor written next cycle
                        if (r_cur == NIL) r_tail <= PW'(r_slot);
                        else r_state <= S_INS2;
                        if (r_cur == NIL) r_state <= S_OUT;
                    end else begin
                        if (r_cur == NIL) r_tail <= PW'(r_slot);
                        r_state <= S_OUT;
                    end
                    if (r_nbr == NIL && (r_head == r_cur || r_count == 7'd0))
                        r_head <= PW'(r_slot);
                    if (r_nbr == NIL || r_cur == NIL) begin
                        r_used[r_slot] <= 1'b1;
                        r_count <= r_count + 7'd1; r_out.length <= r_count + 7'd1;
                    end
                end
                S_DEL: begin
                    if (rprev == NIL) r_head <= rnext;
                    if (rnext == NIL) r_tail <= rprev;
                    r_used[r_cur[AW-1:0]] <= 1'b0;
                    r_count <= r_count - 7'd1; r_out.length <= r_count - 7'd1;
                    r_nbr <= rprev; r_cur <= rnext; r_state <= S_DEL2;
                end
                S_DEL2: r_state <= S_OUT;
                S_OUT: if (out_free) begin
                    r_ovalid <= 1'b1; r_state <= S_IDLE;
                end
                // Read stream: address issued, data next cycle
                S_RD: r_state <= S_RDO;
                S_RDO: if (out_free) begin
                    r_ovalid <= 1'b1;
                    r_out <= '{out_value: rval,
                               out_index: fwd ? r_k[5:0] : 6'(r_count - 7'd1 - r_k),
                               length: r_count, status: ST_OK,
                               last: (r_k + 7'd1 == r_count)};
                    r_k <= r_k + 7'd1;
                    r_cur <= fwd ? rnext : rprev;
                    r_state <= (r_k + 7'd1 == r_count) ? S_IDLE : S_RD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* tb/doubly_linked_list_manager_test.sv */
// Self-checking testbench for doubly_linked_list_manager: directed and random command
// streams are checked against a queue-based model of the list. Depends on dll_pkg and the RTL.
module doubly_linked_list_manager_test
    import dll_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 32;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;     // cmd, item_value, position
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // out_value, out_index, length, status
    logic        m_axis_tlast;

    int  errors = 0;
    int  cmds_sent = 0;
    bit  quiet = 1'b0;      // no idling on either side in the closing stretch

    doubly_linked_list_manager #(.CAPACITY(CAP)) u_top (.*);

    always #10 i_clk = ~i_clk;

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // Tracks the list contents in list order and the results still owed
    class list_scoreboard;
        logic signed [31:0] contents[$];
        t_result            owed[$];
        int                 seen = 0;

        function void note(logic [3:0] cmd, logic signed [31:0] v, logic [5:0] pos);
            t_result r;
            logic [1:0] st;
            int n;
            st = ST_OK;
            n = contents.size();
            case (cmd)
                CMD_INS_FRONT: if (n >= CAP) st = ST_FULL; else contents.push_front(v);
                CMD_INS_AT: begin
                    if (!(pos < n || (n == 0 && pos == 0))) st = ST_BOUND;
                    else if (n >= CAP) st = ST_FULL;
                    else contents.insert(pos, v);
                end
                CMD_INS_BACK:  if (n >= CAP) st = ST_FULL; else contents.push_back(v);
                CMD_DEL_FRONT: if (n == 0) st = ST_EMPTY; else void'(contents.pop_front());
                CMD_DEL_AT: begin
                    if (n == 0) st = ST_EMPTY;
                    else if (pos >= n) st = ST_BOUND;
                    else contents.delete(pos);
                end
                CMD_DEL_BACK:  if (n == 0) st = ST_EMPTY; else void'(contents.pop_back());
                CMD_CLEAR:     contents.delete();
                CMD_READ_FWD, CMD_READ_BACK: begin
                    if (n == 0) st = ST_EMPTY;
                    else begin
                        // one transfer per element, walking from the chosen end
                        for (int k = 0; k < n; k++) begin
                            r.out_index = (cmd == CMD_READ_FWD) ? 6'(k) : 6'(n - 1 - k);
                            r.out_value = contents[r.out_index];
                            r.length    = 7'(n);
                            r.status    = ST_OK;
                            r.last      = (k == n - 1);
                            owed.push_back(r);
                        end
                        return;
                    end
                end
                default: ;
            endcase
            r.out_value = '0;
            r.out_index = '0;
            r.length    = 7'(contents.size());
            r.status    = st;
            r.last      = 1'b1;
            owed.push_back(r);
        endfunction

        task check(t_result got);
            t_result e;
            seen++;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            e = owed.pop_front();
            if (got.out_value !== e.out_value)
                report($sformatf("out_value %0d, want %0d", $signed(got.out_value),
                                 $signed(e.out_value)));
            if (got.out_index !== e.out_index)
                report($sformatf("out_index %0d, want %0d", got.out_index, e.out_index));
            if (got.length !== e.length)
                report($sformatf("length %0d, want %0d", got.length, e.length));
            if (got.status !== e.status)
                report($sformatf("status %0d, want %0d", got.status, e.status));
            if (got.last !== e.last)
                report($sformatf("last %0b, want %0b", got.last, e.last));
        endtask
    endclass

    list_scoreboard sb = new();

    // Output monitor: one result per transfer
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.out_value = m_axis_tdata[31:0];
            got.out_index = m_axis_tdata[37:32];
            got.length    = m_axis_tdata[44:38];
            got.status    = m_axis_tdata[46:45];
            got.last      = m_axis_tlast;
            sb.check(got);
        end
    end

    // Receiver backpressure: bursts of stall, none once quiet
    initial begin
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                m_axis_tready = 1'b1;
            end else begin
                m_axis_tready = 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
                if (!quiet && $urandom_range(0, 2) == 0) begin
                    m_axis_tready = 1'b0;
                    repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
                end
            end
        end
    end

    // Present one command and hold it until transferred
    task automatic send(input logic [3:0] cmd, input logic signed [31:0] v,
                        input logic [5:0] pos);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {6'd0, pos, v, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note(cmd, v, pos);
        cmds_sent++;
    endtask

    task automatic send_random();
        int len, r;
        logic [3:0] cmd;
        logic [31:0] v;
        logic [5:0] pos;
        len = sb.contents.size();
        r = $urandom_range(0, 99);
        if (r < 12) cmd = CMD_INS_FRONT;
        else if (r < 24) cmd = CMD_INS_AT;
        else if (r < 36) cmd = CMD_INS_BACK;
        else if (r < 44) cmd = CMD_DEL_FRONT;
        else if (r < 56) cmd = CMD_DEL_AT;
        else if (r < 64) cmd = CMD_DEL_BACK;
        else if (r < 66) cmd = CMD_CLEAR;
        else if (r < 76) cmd = CMD_READ_FWD;
        else if (r < 86) cmd = CMD_READ_BACK;
        else if (r < 89) cmd = 4'($urandom_range(9, 15));
        // keep the list wandering between empty and full
        else cmd = (len < 20) ? CMD_INS_AT : CMD_DEL_AT;
        case ($urandom_range(0, 9))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'hFFFF_FFFF;
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 4) == 0) pos = 6'($urandom_range(0, 63));
        else pos = 6'($urandom_range(0, (len > 0) ? len - 1 : 0));
        send(cmd, v, pos);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty list corner cases, then small-list inserts, reads, deletes and unused codes
        send(CMD_READ_FWD, 0, 0);
        send(CMD_READ_BACK, 0, 0);
        send(CMD_DEL_FRONT, 0, 0);
        send(CMD_DEL_AT, 0, 0);
        send(CMD_DEL_BACK, 0, 0);
        send(CMD_INS_AT, 5, 1);
        send(CMD_INS_AT, 32'h7FFF_FFFF, 0);
        send(CMD_INS_FRONT, 32'h8000_0000, 0);
        send(CMD_INS_BACK, -1, 63);
        send(CMD_INS_AT, 1234, 1);          // lands in the middle
        send(CMD_INS_AT, 77, 4);            // past the end
        send(CMD_READ_FWD, 0, 0);
        send(CMD_READ_BACK, 0, 0);
        send(CMD_DEL_AT, 0, 63);
        send(CMD_DEL_AT, 0, 2);
        send(4'd15, 32'hFFFF_FFFF, 63);
        send(4'd9, 0, 0);
        // Fill the store, then hit it with every insert form
        while (sb.contents.size() < CAP) send(CMD_INS_BACK, $urandom, 0);
        send(CMD_INS_FRONT, 1, 0);
        send(CMD_INS_BACK, 2, 0);
        send(CMD_INS_AT, 3, 31);
        send(CMD_INS_AT, 4, 40);            // bounds ahead of fullness
        send(CMD_READ_BACK, 0, 0);
        send(CMD_CLEAR, 0, 0);
        send(CMD_READ_FWD, 0, 0);

        for (int i = 0; i < 400; i++) begin
            if (i == 200) begin
                // let the block drain completely before resuming
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                while (sb.owed.size() != 0) @(posedge i_clk);
            end
            if (i == 340) quiet = 1'b1;
            send_random();
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;

        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (sb.owed.size() != 0) report($sformatf("%0d results never came", sb.owed.size()));

        $display("Covered %0d commands (all codes, empty/full/bounds cases), %0d results.",
                 cmds_sent, sb.seen);
        if (errors == 0)
            $display("doubly_linked_list_manager_test: clean");
        else
            $display("doubly_linked_list_manager_test: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #40ms;
        $display("timeout waiting for the block");
        $display("doubly_linked_list_manager_test: errors");
        $finish;
    end
endmodule
